>>> design/assert_macros.svh
// assertion macros used by arm_data_processing_execute
// no dependencies; include with the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> design/arm_dp_pkg.sv
// shared constants and helpers for the arm data-processing execute block
// no dependencies
package arm_dp_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned FLAGS_W = 8;
    localparam int unsigned REG_W   = 4;

    // data-processing opcodes, bits 24..21
    localparam logic [3:0] OP_AND = 4'h0;
    localparam logic [3:0] OP_EOR = 4'h1;
    localparam logic [3:0] OP_SUB = 4'h2;
    localparam logic [3:0] OP_RSB = 4'h3;
    localparam logic [3:0] OP_ADD = 4'h4;
    localparam logic [3:0] OP_ADC = 4'h5;
    localparam logic [3:0] OP_SBC = 4'h6;
    localparam logic [3:0] OP_RSC = 4'h7;
    localparam logic [3:0] OP_TST = 4'h8;
    localparam logic [3:0] OP_TEQ = 4'h9;
    localparam logic [3:0] OP_CMP = 4'hA;
    localparam logic [3:0] OP_CMN = 4'hB;
    localparam logic [3:0] OP_ORR = 4'hC;
    localparam logic [3:0] OP_MOV = 4'hD;
    localparam logic [3:0] OP_BIC = 4'hE;
    localparam logic [3:0] OP_MVN = 4'hF;

    // shift types, bits 6..5
    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    // condition codes, bits 31..28
    localparam logic [3:0] CC_EQ = 4'h0;
    localparam logic [3:0] CC_NE = 4'h1;
    localparam logic [3:0] CC_CS = 4'h2;
    localparam logic [3:0] CC_CC = 4'h3;
    localparam logic [3:0] CC_MI = 4'h4;
    localparam logic [3:0] CC_PL = 4'h5;
    localparam logic [3:0] CC_VS = 4'h6;
    localparam logic [3:0] CC_VC = 4'h7;
    localparam logic [3:0] CC_HI = 4'h8;
    localparam logic [3:0] CC_LS = 4'h9;
    localparam logic [3:0] CC_GE = 4'hA;
    localparam logic [3:0] CC_LT = 4'hB;
    localparam logic [3:0] CC_GT = 4'hC;
    localparam logic [3:0] CC_LE = 4'hD;
    localparam logic [3:0] CC_AL = 4'hE;
    // never: the condition always fails
    localparam logic [3:0] CC_NV = 4'hF;

    localparam logic [REG_W-1:0] REG_PC = 4'hF;
    localparam logic [WORD_W-1:0] PC_AHEAD = 32'd8;

    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [FLAGS_W-1:0] t_flags;

    // condition check on nzcv (n in bit 3)
    function automatic logic cond_holds(input logic [3:0] cond, input logic [3:0] nzcv);
        logic n, z, c, v, res;
        n = nzcv[3];
        z = nzcv[2];
        c = nzcv[1];
        v = nzcv[0];
        case (cond)
            CC_EQ:   res = z;
            CC_NE:   res = !z;
            CC_CS:   res = c;
            CC_CC:   res = !c;
            CC_MI:   res = n;
            CC_PL:   res = !n;
            CC_VS:   res = v;
            CC_VC:   res = !v;
            CC_HI:   res = c && !z;
            CC_LS:   res = !c || z;
            CC_GE:   res = (n == v);
            CC_LT:   res = (n != v);
            CC_GT:   res = !z && (n == v);
            CC_LE:   res = z || (n != v);
            CC_AL:   res = 1'b1;
            default: res = 1'b0;
        endcase
        return res;
    endfunction

endpackage

>>> design/arm_data_processing_execute.sv
// arm data-processing execute: an input beat reaches the result beat through two registers
// (input register, then result register); one beat per cycle while the output is not stalled.
// the path between the registers is one barrel shifter, one 33-bit adder and
// flag selection. reset (i_rst_n low, synchronous) empties both stages; payload
// registers are not reset. depends on arm_dp_pkg and assert_macros.svh
`include "assert_macros.svh"

module arm_data_processing_execute (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input channel
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  arm_dp_pkg::t_word       i_instruction_word,
    input  arm_dp_pkg::t_word       i_instruction_address,
    input  arm_dp_pkg::t_word       i_first_operand_value,
    input  arm_dp_pkg::t_word       i_shifter_source_value,
    input  arm_dp_pkg::t_flags      i_flags_byte_in,
    // result channel
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_handled,
    output logic                    o_condition_passed,
    output logic                    o_write_enable,
    output logic [3:0]              o_dest_index,
    output arm_dp_pkg::t_word       o_result_value,
    output arm_dp_pkg::t_flags      o_flags_byte_out
);
    import arm_dp_pkg::*;

    // ---------------------------------------------------------------
    // pipeline control: input stage moves on whenever the result
    // register is empty or being drained this cycle
    // ---------------------------------------------------------------
    logic   r_in_valid;
    t_word  r_word;
    t_word  r_addr;
    t_word  r_rn_val;
    t_word  r_rm_val;
    t_flags r_fin;

    logic   out_free;
    logic   advance;
    logic   in_accept;

    assign out_free   = !o_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;
    assign in_accept  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (in_accept) begin
            r_word   <= i_instruction_word;
            r_addr   <= i_instruction_address;
            r_rn_val <= i_first_operand_value;
            r_rm_val <= i_shifter_source_value;
            r_fin    <= i_flags_byte_in;
        end
    end

    // ---------------------------------------------------------------
    // decode
    // ---------------------------------------------------------------
    logic [3:0] op;
    logic       set_flags;
    logic [3:0] rd;
    logic [3:0] rn;
    logic [3:0] rm;
    logic [1:0] stype;
    logic [4:0] simm;
    logic       imm_form;
    logic       supported;
    logic       passed;
    t_word      pc8;

    assign op        = r_word[24:21];
    assign set_flags = r_word[20];
    assign rd        = r_word[15:12];
    assign rn        = r_word[19:16];
    assign rm        = r_word[3:0];
    assign stype     = r_word[6:5];
    assign simm      = r_word[11:7];
    assign imm_form  = r_word[25];
    assign pc8       = r_addr + PC_AHEAD;

    // unsupported: non data-processing class, carry-in ops, compares
    // without s, pc destination, register-specified shift, rrx
    always_comb begin
        supported = 1'b1;
        if (r_word[27:26] != 2'b00) supported = 1'b0;
        if (op == OP_ADC || op == OP_SBC || op == OP_RSC) supported = 1'b0;
        if ((op == OP_TST || op == OP_TEQ || op == OP_CMP || op == OP_CMN) && !set_flags)
            supported = 1'b0;
        if (rd == REG_PC) supported = 1'b0;
        if (!imm_form && r_word[4]) supported = 1'b0;
        if (!imm_form && stype == SH_ROR && simm == 5'd0) supported = 1'b0;
    end

    assign passed = cond_holds(r_word[31:28], r_fin[7:4]);

    // ---------------------------------------------------------------
    // shifter: operand 2 and shifter carry
    // ---------------------------------------------------------------
    logic [4:0]         rot;
    logic [2*WORD_W-1:0] imm_dbl;
    logic [2*WORD_W-1:0] imm_shr;
    t_word              src;
    logic [WORD_W:0]    lsl_ext;
    logic [WORD_W:0]    lsr_ext;
    logic signed [WORD_W:0] asr_ext;
    logic [2*WORD_W-1:0] ror_shr;
    t_word              op_b;
    logic               carry_kept;
    logic               sh_c;

    assign rot     = {r_word[11:8], 1'b0};
    assign imm_dbl = {24'd0, r_word[7:0], 24'd0, r_word[7:0]};
    assign imm_shr = imm_dbl >> rot;
    assign src     = (rm == REG_PC) ? pc8 : r_rm_val;
    assign lsl_ext = {1'b0, src} << simm;
    // right shifts carry one guard bit below the word: it holds the carry out
    assign lsr_ext = {src, 1'b0} >> simm;
    assign asr_ext = $signed({src, 1'b0}) >>> simm;
    assign ror_shr = {src, src} >> simm;

    always_comb begin
        op_b       = src;
        carry_kept = 1'b1;
        sh_c       = 1'b0;
        if (imm_form) begin
            op_b = imm_shr[WORD_W-1:0];
            if (rot != 5'd0) begin
                carry_kept = 1'b0;
                sh_c       = imm_shr[WORD_W-1];
            end
        end else begin
            case (stype)
                SH_LSL: begin
                    if (simm != 5'd0) begin
                        op_b       = lsl_ext[WORD_W-1:0];
                        carry_kept = 1'b0;
                        sh_c       = lsl_ext[WORD_W];
                    end
                end
                SH_LSR: begin
                    carry_kept = 1'b0;
                    // lsr #0 means a shift by 32
                    op_b = (simm == 5'd0) ? '0 : lsr_ext[WORD_W:1];
                    sh_c = (simm == 5'd0) ? src[WORD_W-1] : lsr_ext[0];
                end
                SH_ASR: begin
                    carry_kept = 1'b0;
                    op_b = (simm == 5'd0) ? {WORD_W{src[WORD_W-1]}} : asr_ext[WORD_W:1];
                    sh_c = (simm == 5'd0) ? src[WORD_W-1] : asr_ext[0];
                end
                SH_ROR: begin
                    carry_kept = 1'b0;
                    op_b = ror_shr[WORD_W-1:0];
                    sh_c = ror_shr[WORD_W-1];
                end
                default: begin
                    op_b = src;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // alu and flag merge
    // ---------------------------------------------------------------
    t_word           op_a;
    logic            is_logical;
    logic            has_dest;
    logic            is_sub;
    t_word           ax;
    t_word           ay;
    logic [WORD_W:0] sum;
    t_word           logic_res;
    t_word           alu_res;
    t_flags          fout;
    logic            ar_v;

    assign op_a       = (rn == REG_PC) ? pc8 : r_rn_val;
    assign is_logical = !(op == OP_SUB || op == OP_RSB || op == OP_ADD
                          || op == OP_CMP || op == OP_CMN);
    assign has_dest   = !(op == OP_TST || op == OP_TEQ || op == OP_CMP || op == OP_CMN);
    assign is_sub     = !(op == OP_ADD || op == OP_CMN);
    assign ax         = (op == OP_RSB) ? op_b : op_a;
    assign ay         = (op == OP_RSB) ? op_a : op_b;
    // subtract as x + ~y + 1 so the carry out is not-borrow
    assign sum        = {1'b0, ax} + {1'b0, (is_sub ? ~ay : ay)} + {{WORD_W{1'b0}}, is_sub};
    assign ar_v       = is_sub ? ((ax[WORD_W-1] ^ ay[WORD_W-1]) & (ax[WORD_W-1] ^ sum[WORD_W-1]))
                               : (~(ax[WORD_W-1] ^ ay[WORD_W-1]) & (ax[WORD_W-1] ^ sum[WORD_W-1]));

    always_comb begin
        case (op)
            OP_AND, OP_TST: logic_res = op_a & op_b;
            OP_EOR, OP_TEQ: logic_res = op_a ^ op_b;
            OP_ORR:         logic_res = op_a | op_b;
            OP_MOV:         logic_res = op_b;
            OP_BIC:         logic_res = op_a & ~op_b;
            default:        logic_res = ~op_b;
        endcase
    end

    always_comb begin
        fout = r_fin;
        if (is_logical) begin
            alu_res = logic_res;
            if (set_flags) begin
                fout = {alu_res[WORD_W-1], (alu_res == '0),
                        (carry_kept ? r_fin[5] : sh_c), r_fin[4:0]};
            end
        end else begin
            alu_res = sum[WORD_W-1:0];
            if (set_flags) begin
                // arithmetic flag writes clear the low nibble
                fout = {alu_res[WORD_W-1], (alu_res == '0), sum[WORD_W], ar_v, 4'd0};
            end
        end
    end

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (out_free) begin
            o_out_valid <= r_in_valid;
        end
        if (advance) begin
            o_handled          <= supported;
            o_condition_passed <= supported && passed;
            o_write_enable     <= supported && passed && has_dest;
            o_dest_index       <= supported ? rd : 4'd0;
            o_result_value     <= (supported && passed) ? alu_res : '0;
            o_flags_byte_out   <= (supported && passed) ? fout : r_fin;
        end
    end

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    `ASSERT_IMPL(a_wr_needs_pass, i_clk, i_rst_n, o_out_valid && o_write_enable,
        o_handled && o_condition_passed)
    `ASSERT_IMPL(a_unhandled_clean, i_clk, i_rst_n, o_out_valid && !o_handled,
        !o_condition_passed && o_dest_index == 4'd0 && o_result_value == '0)
    `ASSERT_IMPL(a_fail_zero_result, i_clk, i_rst_n, o_out_valid && !o_condition_passed,
        !o_write_enable && o_result_value == '0)
    `ASSERT_NEXT(a_stage_holds, i_clk, i_rst_n, r_in_valid && !out_free,
        r_in_valid && $stable(r_word))

endmodule

>>> tb/sv/arm_dp_result_checker.sv
`timescale 1ns / 1ps
// result checker for arm_data_processing_execute: predicts every input beat
// and compares result beats in order; depends on arm_dp_pkg
module arm_dp_result_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  arm_dp_pkg::t_word   i_instruction_word,
    input  arm_dp_pkg::t_word   i_instruction_address,
    input  arm_dp_pkg::t_word   i_first_operand_value,
    input  arm_dp_pkg::t_word   i_shifter_source_value,
    input  arm_dp_pkg::t_flags  i_flags_byte_in,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic                i_handled,
    input  logic                i_condition_passed,
    input  logic                i_write_enable,
    input  logic [3:0]          i_dest_index,
    input  arm_dp_pkg::t_word   i_result_value,
    input  arm_dp_pkg::t_flags  i_flags_byte_out,
    output int unsigned         o_fail_count,
    output int unsigned         o_outstanding
);
    import arm_dp_pkg::*;

    typedef struct packed {
        logic       handled;
        logic       passed;
        logic       write_en;
        logic [3:0] dest;
        t_word      result;
        t_flags     flags;
    } t_dp_outcome;

    t_dp_outcome expected_outcomes[$];
    int unsigned mismatch_count = 0;
    int unsigned pending_count  = 0;

    assign o_fail_count  = mismatch_count;
    assign o_outstanding = pending_count;

    function automatic logic condition_met(input logic [3:0] cond, input logic [3:0] nzcv);
        logic n, z, c, v;
        n = nzcv[3];
        z = nzcv[2];
        c = nzcv[1];
        v = nzcv[0];
        case (cond)
            CC_EQ: return z;
            CC_NE: return !z;
            CC_CS: return c;
            CC_CC: return !c;
            CC_MI: return n;
            CC_PL: return !n;
            CC_VS: return v;
            CC_VC: return !v;
            CC_HI: return c && !z;
            CC_LS: return !c || z;
            CC_GE: return n == v;
            CC_LT: return n != v;
            CC_GT: return !z && (n == v);
            CC_LE: return z || (n != v);
            CC_AL: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic t_dp_outcome execute_dp_word(input t_word w, input t_word addr,
                                                    input t_word rn_val, input t_word rm_val,
                                                    input t_flags fin);
        t_dp_outcome r;
        logic [3:0]  op, rd, rn, rm;
        logic [1:0]  stype;
        logic [4:0]  simm, rot, sft;
        logic        s, imm, supported, carry_kept, sh_c, logical, c, v;
        t_word       pc8, src, a, b, x, y, res;
        logic [32:0] wide;
        logic [63:0] dbl;
        t_flags      fout;
        op    = w[24:21];
        s     = w[20];
        rn    = w[19:16];
        rd    = w[15:12];
        rm    = w[3:0];
        stype = w[6:5];
        simm  = w[11:7];
        imm   = w[25];
        pc8   = addr + PC_AHEAD;
        supported = (w[27:26] == 2'b00)
            && !(op == OP_ADC || op == OP_SBC || op == OP_RSC)
            && !((op == OP_TST || op == OP_TEQ || op == OP_CMP || op == OP_CMN) && !s)
            && (rd != REG_PC)
            && !(!imm && w[4])
            && !(!imm && stype == SH_ROR && simm == 5'd0);
        r = '0;
        r.flags = fin;
        if (!supported) return r;
        r.handled = 1'b1;
        r.dest    = rd;
        if (!condition_met(w[31:28], fin[7:4])) return r;
        r.passed = 1'b1;

        carry_kept = 1'b1;
        sh_c       = 1'b0;
        if (imm) begin
            rot = {w[11:8], 1'b0};
            dbl = {24'd0, w[7:0], 24'd0, w[7:0]} >> rot;
            b   = dbl[31:0];
            if (rot != 5'd0) begin
                carry_kept = 1'b0;
                sh_c       = b[31];
            end
        end else begin
            src = (rm == REG_PC) ? pc8 : rm_val;
            case (stype)
                SH_LSL: begin
                    if (simm == 5'd0) begin
                        b = src;
                    end else begin
                        b          = src << simm;
                        carry_kept = 1'b0;
                        sh_c       = src[32 - simm];
                    end
                end
                SH_LSR: begin
                    carry_kept = 1'b0;
                    sh_c       = (simm == 5'd0) ? src[31] : src[simm - 1];
                    b          = (simm == 5'd0) ? '0 : (src >> simm);
                end
                SH_ASR: begin
                    // #0 means a shift by 32, same as 31 for the result
                    carry_kept = 1'b0;
                    sft        = (simm == 5'd0) ? 5'd31 : simm;
                    sh_c       = (simm == 5'd0) ? src[31] : src[simm - 1];
                    b          = $signed(src) >>> sft;
                end
                default: begin
                    carry_kept = 1'b0;
                    sh_c       = src[simm - 1];
                    dbl        = {src, src} >> simm;
                    b          = dbl[31:0];
                end
            endcase
        end
        a = (rn == REG_PC) ? pc8 : rn_val;

        logical = !(op == OP_SUB || op == OP_RSB || op == OP_ADD || op == OP_CMP || op == OP_CMN);
        fout = fin;
        if (logical) begin
            case (op)
                OP_AND, OP_TST: res = a & b;
                OP_EOR, OP_TEQ: res = a ^ b;
                OP_ORR:         res = a | b;
                OP_MOV:         res = b;
                OP_BIC:         res = a & ~b;
                default:        res = ~b;
            endcase
            if (s) begin
                fout[7] = res[31];
                fout[6] = (res == '0);
                if (!carry_kept) fout[5] = sh_c;
            end
        end else begin
            if (op == OP_RSB) begin
                x = b;
                y = a;
            end else begin
                x = a;
                y = b;
            end
            if (op == OP_ADD || op == OP_CMN) begin
                wide = {1'b0, x} + {1'b0, y};
                res  = wide[31:0];
                c    = wide[32];
                v    = ~(x[31] ^ y[31]) & (x[31] ^ res[31]);
            end else begin
                res = x - y;
                c   = (x >= y);
                v   = (x[31] ^ y[31]) & (x[31] ^ res[31]);
            end
            if (s) fout = {res[31], (res == '0), c, v, 4'b0000};
        end

        r.write_en = !(op == OP_TST || op == OP_TEQ || op == OP_CMP || op == OP_CMN);
        r.result   = res;
        r.flags    = fout;
        return r;
    endfunction

    task automatic check_field(input string name, input t_word exp_v, input t_word act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_dp_outcome exp_r;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (expected_outcomes.size() == 0) begin
                    $error("result beat with no instruction pending");
                    mismatch_count++;
                end else begin
                    exp_r = expected_outcomes.pop_front();
                    check_field("handled", 32'(exp_r.handled), 32'(i_handled));
                    check_field("condition_passed", 32'(exp_r.passed),
                                32'(i_condition_passed));
                    check_field("write_enable", 32'(exp_r.write_en), 32'(i_write_enable));
                    check_field("dest_index", 32'(exp_r.dest), 32'(i_dest_index));
                    check_field("result_value", exp_r.result, i_result_value);
                    check_field("flags_byte_out", 32'(exp_r.flags), 32'(i_flags_byte_out));
                end
            end
            if (i_in_valid && i_in_ready)
                expected_outcomes.push_back(execute_dp_word(i_instruction_word,
                    i_instruction_address, i_first_operand_value, i_shifter_source_value,
                    i_flags_byte_in));
            pending_count = expected_outcomes.size();
        end
    end

endmodule

>>> tb/sv/arm_data_processing_execute_tb.sv
`timescale 1ns / 1ps
// top of the arm_data_processing_execute testbench: clock, reset, stimulus
// and verdict; depends on arm_dp_pkg and arm_dp_result_checker
module arm_data_processing_execute_tb;
    import arm_dp_pkg::*;

    localparam int unsigned RANDOM_PER_PHASE  = 375;
    localparam int unsigned CYCLE_LIMIT       = 200000;
    localparam int unsigned LONG_STALL_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES      = 10;
    // bits that push a word out of the data-processing fast path
    localparam t_word REG_SHIFT_BIT    = 32'h0000_0010;
    localparam t_word LOAD_STORE_CLASS = 32'h0400_0000;

    // every opcode the fast path executes
    localparam logic [3:0] HANDLED_OPS [13] = '{OP_AND, OP_EOR, OP_SUB, OP_RSB, OP_ADD,
        OP_TST, OP_TEQ, OP_CMP, OP_CMN, OP_ORR, OP_MOV, OP_BIC, OP_MVN};

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_word       in_word  = '0;
    t_word       in_addr  = '0;
    t_word       in_rn    = '0;
    t_word       in_rm    = '0;
    t_flags      in_flags = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        handled, cond_passed, write_en;
    logic [3:0]  dest_index;
    t_word       result_value;
    t_flags      flags_out;

    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned cycle_count    = 0;
    int unsigned send_idle_pct  = 13;
    int unsigned recv_idle_pct  = 57;
    bit          long_stall_req = 1'b0;

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    arm_data_processing_execute i_dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_in_valid             (in_valid),
        .o_in_ready             (in_ready),
        .i_instruction_word     (in_word),
        .i_instruction_address  (in_addr),
        .i_first_operand_value  (in_rn),
        .i_shifter_source_value (in_rm),
        .i_flags_byte_in        (in_flags),
        .o_out_valid            (out_valid),
        .i_out_ready            (out_ready),
        .o_handled              (handled),
        .o_condition_passed     (cond_passed),
        .o_write_enable         (write_en),
        .o_dest_index           (dest_index),
        .o_result_value         (result_value),
        .o_flags_byte_out       (flags_out)
    );

    arm_dp_result_checker i_checker (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_in_valid             (in_valid),
        .i_in_ready             (in_ready),
        .i_instruction_word     (in_word),
        .i_instruction_address  (in_addr),
        .i_first_operand_value  (in_rn),
        .i_shifter_source_value (in_rm),
        .i_flags_byte_in        (in_flags),
        .i_out_valid            (out_valid),
        .i_out_ready            (out_ready),
        .i_handled              (handled),
        .i_condition_passed     (cond_passed),
        .i_write_enable         (write_en),
        .i_dest_index           (dest_index),
        .i_result_value         (result_value),
        .i_flags_byte_out       (flags_out),
        .o_fail_count           (fail_count),
        .o_outstanding          (outstanding)
    );

    // assemble a data-processing word from its fields
    function automatic t_word dp_word(input logic [3:0] cond, input logic imm,
                                      input logic [3:0] op, input logic s,
                                      input logic [3:0] rn, input logic [3:0] rd,
                                      input logic [11:0] op2);
        return {cond, 2'b00, imm, op, s, rn, rd, op2};
    endfunction

    // immediate-shifted register operand 2
    function automatic logic [11:0] reg_op2(input logic [4:0] amt, input logic [1:0] st,
                                            input logic [3:0] rm);
        return {amt, st, 1'b0, rm};
    endfunction

    // operand values biased toward the carry and overflow corners
    function automatic t_word pick_operand();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return 32'd1;
            default: return $urandom();
        endcase
    endfunction

    // offer one beat; called and returns just after a falling edge.
    // random gaps first, then valid stays high until the beat is taken
    task automatic send_beat(input t_word w, input t_word addr, input t_word rn_v,
                             input t_word rm_v, input t_flags f);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_word  = w;
        in_addr  = addr;
        in_rn    = rn_v;
        in_rm    = rm_v;
        in_flags = f;
        do begin
            @(posedge i_clk);
        end while (!in_ready);
        @(negedge i_clk);
    endtask

    // mostly well-formed fast-path words with random content, plus raw noise
    // and words broken in exactly one way
    task automatic run_random_phase(input int unsigned count);
        t_word       w;
        logic [3:0]  op, cond, rd;
        logic        s, imm;
        logic [11:0] op2;
        logic [4:0]  amt;
        logic [1:0]  st;
        int unsigned kind;
        repeat (count) begin
            kind = $urandom_range(99);
            if (kind < 15) begin
                w = $urandom();
            end else begin
                // half always-execute so most words reach the alu
                cond = $urandom_range(1) ? CC_AL : 4'($urandom_range(15));
                op   = HANDLED_OPS[$urandom_range(12)];
                s    = (op == OP_TST || op == OP_TEQ || op == OP_CMP || op == OP_CMN)
                       ? 1'b1 : 1'($urandom_range(1));
                imm  = 1'($urandom_range(1));
                rd   = 4'($urandom_range(14));
                if (imm) begin
                    op2 = 12'($urandom());
                end else begin
                    case ($urandom_range(3))
                        0: amt = 5'd0;
                        1: amt = 5'd31;
                        2: amt = 5'd1;
                        default: amt = 5'($urandom());
                    endcase
                    st = 2'($urandom());
                    // keep clear of rrx here
                    if (st == SH_ROR && amt == 5'd0) amt = 5'd1;
                    op2 = reg_op2(amt, st, 4'($urandom()));
                end
                w = dp_word(cond, imm, op, s, 4'($urandom()), rd, op2);
                if (kind < 30) begin
                    case ($urandom_range(5))
                        0: w[27:26] = 2'($urandom_range(3, 1));
                        1: w[24:21] = 4'($urandom_range(OP_RSC, OP_ADC));
                        2: begin
                            w[24:21] = 4'(OP_TST + $urandom_range(3));
                            w[20]    = 1'b0;
                        end
                        3: w[15:12] = REG_PC;
                        4: begin
                            w[25] = 1'b0;
                            w[4]  = 1'b1;
                        end
                        default: begin
                            w[25]    = 1'b0;
                            w[6:5]   = SH_ROR;
                            w[11:7]  = 5'd0;
                        end
                    endcase
                end
            end
            send_beat(w, $urandom(), pick_operand(), pick_operand(), 8'($urandom()));
        end
    endtask

    // receiver: random backpressure, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (long_stall_req) begin
                long_stall_req = 1'b0;
                out_ready      = 1'b0;
                repeat (LONG_STALL_CYCLES) @(negedge i_clk);
            end
            out_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // run-away guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("arm_data_processing_execute verification failed");
            $finish;
        end
    end

    initial begin
        t_word w;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // rotated immediate, rotation 0: carry kept, zero result
        send_beat(dp_word(CC_AL, 1'b1, OP_MOV, 1'b1, 4'd0, 4'd1, 12'h000),
                  32'h0, 32'h0, 32'h0, 8'h2F);
        // rotated immediate with rotation: carry from bit 31
        send_beat(dp_word(CC_AL, 1'b1, OP_MOV, 1'b1, 4'd0, 4'd2, {4'd1, 8'hFF}),
                  32'h100, 32'h0, 32'h0, 8'h0A);
        // lsl #0 keeps carry
        send_beat(dp_word(CC_AL, 1'b0, OP_AND, 1'b1, 4'd4, 4'd3, reg_op2(5'd0, SH_LSL, 4'd5)),
                  32'h104, '1, '1, 8'hD5);
        // lsl #31
        send_beat(dp_word(CC_AL, 1'b0, OP_ORR, 1'b1, 4'd2, 4'd3, reg_op2(5'd31, SH_LSL, 4'd1)),
                  32'h108, 32'h0, 32'h3, 8'h00);
        // lsr #0 is a shift by 32
        send_beat(dp_word(CC_AL, 1'b0, OP_EOR, 1'b1, 4'd6, 4'd7, reg_op2(5'd0, SH_LSR, 4'd8)),
                  32'h10C, 32'h1234_5678, 32'h8000_0000, 8'h0F);
        send_beat(dp_word(CC_AL, 1'b0, OP_MOV, 1'b1, 4'd0, 4'd9, reg_op2(5'd1, SH_LSR, 4'd3)),
                  32'h110, 32'h0, 32'h1, 8'h00);
        // asr #0 is a shift by 32, sign filled
        send_beat(dp_word(CC_AL, 1'b0, OP_MOV, 1'b1, 4'd0, 4'd10, reg_op2(5'd0, SH_ASR, 4'd2)),
                  32'h114, 32'h0, 32'h8000_0001, 8'h00);
        // ror #1 and ror #31
        send_beat(dp_word(CC_AL, 1'b0, OP_MOV, 1'b1, 4'd0, 4'd11, reg_op2(5'd1, SH_ROR, 4'd2)),
                  32'h118, 32'h0, 32'h1, 8'h00);
        send_beat(dp_word(CC_AL, 1'b0, OP_MVN, 1'b1, 4'd0, 4'd12, reg_op2(5'd31, SH_ROR, 4'd2)),
                  32'h11C, 32'h0, 32'h8000_0000, 8'hF0);
        // a compare with S: value computed, no write; then a bic with S
        send_beat(dp_word(CC_AL, 1'b0, OP_TST, 1'b1, 4'd1, 4'd0, reg_op2(5'd0, SH_LSL, 4'd2)),
                  32'h120, 32'hF0F0_F0F0, 32'h0F0F_0F0F, 8'h00);
        send_beat(dp_word(CC_AL, 1'b0, OP_BIC, 1'b1, 4'd1, 4'd2, reg_op2(5'd4, SH_ASR, 4'd3)),
                  32'h124, '1, 32'h7FFF_FFF0, 8'h3C);
        // signed overflow and carry out on add
        send_beat(dp_word(CC_AL, 1'b0, OP_ADD, 1'b1, 4'd1, 4'd2, reg_op2(5'd0, SH_LSL, 4'd3)),
                  32'h128, 32'h7FFF_FFFF, 32'h1, 8'h0F);
        send_beat(dp_word(CC_AL, 1'b1, OP_ADD, 1'b1, 4'd1, 4'd2, 12'h001),
                  32'h12C, '1, 32'h0, 8'hFF);
        // borrow and overflow on subtract, then cmp of equal values and cmn with carry out
        send_beat(dp_word(CC_AL, 1'b1, OP_SUB, 1'b1, 4'd1, 4'd2, 12'h001),
                  32'h130, 32'h0, 32'h0, 8'h00);
        send_beat(dp_word(CC_AL, 1'b1, OP_RSB, 1'b1, 4'd1, 4'd2, 12'h000),
                  32'h134, 32'h8000_0000, 32'h0, 8'h00);
        send_beat(dp_word(CC_AL, 1'b0, OP_CMP, 1'b1, 4'd4, 4'd0, reg_op2(5'd0, SH_LSL, 4'd5)),
                  32'h138, 32'h5A5A_5A5A, 32'h5A5A_5A5A, 8'h00);
        send_beat(dp_word(CC_AL, 1'b1, OP_CMN, 1'b1, 4'd4, 4'd0, 12'h0FF),
                  32'h13C, 32'hFFFF_FF01, 32'h0, 8'h00);
        // without S the flags pass through
        send_beat(dp_word(CC_AL, 1'b1, OP_ADD, 1'b0, 4'd1, 4'd2, 12'h0FF),
                  32'h140, '1, 32'h0, 8'hA5);
        // pc as both operands, address wraps past the top
        send_beat(dp_word(CC_AL, 1'b0, OP_ADD, 1'b1, REG_PC, 4'd3,
                          reg_op2(5'd0, SH_LSL, REG_PC)),
                  32'hFFFF_FFFC, 32'h1111_1111, 32'h2222_2222, 8'h00);
        // condition fails: eq with z clear, then never
        send_beat(dp_word(CC_EQ, 1'b1, OP_MOV, 1'b1, 4'd0, 4'd5, 12'h0FF),
                  32'h144, 32'h0, 32'h0, 8'hB0);
        send_beat(dp_word(CC_NV, 1'b1, OP_MOV, 1'b1, 4'd0, 4'd6, 12'h0FF),
                  32'h148, 32'h0, 32'h0, 8'hF0);
        // unhandled forms: carry-in arithmetic, compare without S, pc
        // destination, register-shifted register, rrx, load/store class
        send_beat(dp_word(CC_AL, 1'b0, OP_ADC, 1'b1, 4'd2, 4'd3, reg_op2(5'd0, SH_LSL, 4'd4)),
                  32'h14C, 32'h1, 32'h1, 8'h20);
        send_beat(dp_word(CC_AL, 1'b1, OP_TST, 1'b0, 4'd1, 4'd0, 12'h0FF),
                  32'h150, 32'h1, 32'h1, 8'h40);
        send_beat(dp_word(CC_AL, 1'b1, OP_MOV, 1'b0, 4'd0, REG_PC, 12'h001),
                  32'h154, 32'h1, 32'h1, 8'h80);
        w = dp_word(CC_AL, 1'b0, OP_ADD, 1'b0, 4'd1, 4'd2, reg_op2(5'd2, SH_LSL, 4'd3));
        send_beat(w | REG_SHIFT_BIT, 32'h158, 32'h1, 32'h1, 8'h10);
        send_beat(dp_word(CC_AL, 1'b0, OP_MOV, 1'b1, 4'd0, 4'd1, reg_op2(5'd0, SH_ROR, 4'd2)),
                  32'h15C, 32'h1, 32'h1, 8'hFF);
        w = dp_word(CC_AL, 1'b1, OP_MOV, 1'b0, 4'd0, 4'd1, 12'h004);
        send_beat(w | LOAD_STORE_CLASS, 32'h160, 32'h1, 32'h1, 8'h00);

        // phase 1: light sender gaps, heavy backpressure
        run_random_phase(RANDOM_PER_PHASE);

        // sender pauses until every result has come back
        in_valid = 1'b0;
        wait (outstanding == 0);
        @(negedge i_clk);

        // phase 2: roles swapped
        send_idle_pct = 57;
        recv_idle_pct = 13;
        run_random_phase(RANDOM_PER_PHASE);

        // phase 3: full rate, opening with a long receiver hold-off so the
        // pipeline fills and stalls the input side
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        long_stall_req = 1'b1;
        run_random_phase(RANDOM_PER_PHASE);

        in_valid = 1'b0;
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("arm_data_processing_execute verification clean");
        end else begin
            $display("arm_data_processing_execute verification failed");
        end
        $finish;
    end

endmodule
